>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the design folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, muted while reset is asserted
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, muted while reset is asserted
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> design/abrf_pkg.sv
// ----------------------------------------------------------------------------
// abrf_pkg
// codes, types and decode helpers for the banked register file
// ----------------------------------------------------------------------------
package abrf_pkg;

    localparam int unsigned DataW   = 32;
    localparam int unsigned ActionW = 3;
    localparam int unsigned ModeW   = 5;
    localparam int unsigned RegW    = 4;
    localparam int unsigned StatusW = 2;

    // processor mode codes
    localparam logic [ModeW-1:0] MODE_USR = 5'd16;
    localparam logic [ModeW-1:0] MODE_FIQ = 5'd17;
    localparam logic [ModeW-1:0] MODE_IRQ = 5'd18;
    localparam logic [ModeW-1:0] MODE_SVC = 5'd19;
    localparam logic [ModeW-1:0] MODE_ABT = 5'd23;
    localparam logic [ModeW-1:0] MODE_UND = 5'd27;
    localparam logic [ModeW-1:0] MODE_SYS = 5'd31;

    localparam logic [RegW-1:0] REG_PC = 4'd15;
    localparam logic [RegW-1:0] REG_SP = 4'd13;

    typedef enum logic [ActionW-1:0] {
        ACT_RD_GPR  = 3'd0,
        ACT_WR_GPR  = 3'd1,
        ACT_RD_SPSR = 3'd2,
        ACT_WR_SPSR = 3'd3,
        ACT_RD_CPSR = 3'd4,
        ACT_WR_CPSR = 3'd5
    } t_action;

    typedef enum logic [StatusW-1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_MODE = 2'd1,
        STAT_NO_SPSR  = 2'd2
    } t_status;

    // exception slot: fiq, irq, svc, abt, und; none for user and system
    typedef enum logic [2:0] {
        SLOT_FIQ  = 3'd0,
        SLOT_IRQ  = 3'd1,
        SLOT_SVC  = 3'd2,
        SLOT_ABT  = 3'd3,
        SLOT_UND  = 3'd4,
        SLOT_NONE = 3'd7
    } t_slot;

    // storage group that one access lands in
    typedef enum logic [2:0] {
        BANK_NONE,
        BANK_LOW,
        BANK_PC,
        BANK_USR,
        BANK_FIQ,
        BANK_EXC,
        BANK_SPSR,
        BANK_CPSR
    } t_bank;

    function automatic t_slot f_exc_slot(input logic [ModeW-1:0] mode);
        t_slot slot;
        case (mode)
            MODE_FIQ: slot = SLOT_FIQ;
            MODE_IRQ: slot = SLOT_IRQ;
            MODE_SVC: slot = SLOT_SVC;
            MODE_ABT: slot = SLOT_ABT;
            MODE_UND: slot = SLOT_UND;
            default:  slot = SLOT_NONE;
        endcase
        return slot;
    endfunction

    function automatic logic f_mode_valid(input logic [ModeW-1:0] mode);
        return (mode == MODE_USR) || (mode == MODE_SYS) || (f_exc_slot(mode) != SLOT_NONE);
    endfunction

endpackage

>>> design/arm_banked_register_file.sv
// ----------------------------------------------------------------------------
// arm_banked_register_file
// banked general, saved status and current status registers, one access
// per word, one result word per access
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | fields
//  in      | input     | i_in_valid / o_in_stall    | action, mode, reg_index, write_data
//  out     | output    | o_out_valid / i_out_stall  | read_data, status
//
//  one word per cycle sustained while out does not stall; each word passes the
//  input register, then decode, register access and result register in one pass
//  a write lands in the register file in the cycle its result is registered,
//  so the next word already reads the new value
//  synchronous active-low reset clears every register file entry and both stages
//  a stall on out holds the result; in stalls only when both stages are full
// ----------------------------------------------------------------------------
module arm_banked_register_file
    import abrf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [ActionW-1:0] i_action,
    input  logic [ModeW-1:0]   i_mode,
    input  logic [RegW-1:0]    i_reg_index,
    input  logic [DataW-1:0]   i_write_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [DataW-1:0]   o_read_data,
    output logic [StatusW-1:0] o_status
);

    // register file
    logic [DataW-1:0] r_low  [8];
    logic [DataW-1:0] r_pc;
    logic [DataW-1:0] r_usr  [7];
    logic [DataW-1:0] r_fiq  [7];
    logic [DataW-1:0] r_exc  [8];
    logic [DataW-1:0] r_spsr [5];
    logic [DataW-1:0] r_cpsr;

    // input stage
    logic               r_s1_valid;
    logic [ActionW-1:0] r_action;
    logic [ModeW-1:0]   r_mode;
    logic [RegW-1:0]    r_reg;
    logic [DataW-1:0]   r_data;

    // result stage
    logic               r_out_valid;
    logic [DataW-1:0]   r_rd;
    logic [StatusW-1:0] r_status;

    logic               out_free;
    logic               in_take;
    logic               advance;
    t_slot              slot;
    logic [2:0]         slot_m1;
    t_bank              bank;
    logic [2:0]         idx;
    logic               is_write;
    t_status            n_status;
    logic [DataW-1:0]   cell_val;
    logic [DataW-1:0]   n_rd;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign slot    = f_exc_slot(r_mode);
    assign slot_m1 = slot - 3'd1;

    // decode the access into a storage group and an entry
    always_comb begin
        bank     = BANK_NONE;
        idx      = r_reg[2:0];
        n_status = STAT_OK;
        case (r_action)
            ACT_RD_GPR, ACT_WR_GPR: begin
                if (!f_mode_valid(r_mode)) begin
                    n_status = STAT_BAD_MODE;
                end else if (!r_reg[3]) begin
                    bank = BANK_LOW;
                end else if (r_reg == REG_PC) begin
                    bank = BANK_PC;
                end else if (slot == SLOT_FIQ) begin
                    bank = BANK_FIQ;
                end else if (r_reg < REG_SP || slot == SLOT_NONE) begin
                    bank = BANK_USR;
                end else begin
                    // r13 and r14 of irq, svc, abt, und sit in pairs
                    bank = BANK_EXC;
                    idx  = {slot_m1[1:0], r_reg[1]};
                end
            end
            ACT_RD_SPSR, ACT_WR_SPSR: begin
                if (!f_mode_valid(r_mode)) begin
                    n_status = STAT_BAD_MODE;
                end else if (slot == SLOT_NONE) begin
                    n_status = STAT_NO_SPSR;
                end else begin
                    bank = BANK_SPSR;
                    idx  = slot;
                end
            end
            ACT_RD_CPSR, ACT_WR_CPSR: begin
                bank = BANK_CPSR;
            end
            default: begin
                bank = BANK_NONE;
            end
        endcase
    end

    assign is_write = r_action[0];

    always_comb begin
        case (bank)
            BANK_LOW:  cell_val = r_low[idx];
            BANK_PC:   cell_val = r_pc;
            BANK_USR:  cell_val = r_usr[idx];
            BANK_FIQ:  cell_val = r_fiq[idx];
            BANK_EXC:  cell_val = r_exc[idx];
            BANK_SPSR: cell_val = r_spsr[idx];
            BANK_CPSR: cell_val = r_cpsr;
            default:   cell_val = '0;
        endcase
        n_rd = is_write ? '0 : cell_val;
    end

    // register file write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_low[i] <= '0;
                r_exc[i] <= '0;
            end
            for (int i = 0; i < 7; i++) begin
                r_usr[i] <= '0;
                r_fiq[i] <= '0;
            end
            for (int i = 0; i < 5; i++) begin
                r_spsr[i] <= '0;
            end
            r_pc   <= '0;
            r_cpsr <= '0;
        end else if (advance && is_write) begin
            case (bank)
                BANK_LOW:  r_low[idx]  <= r_data;
                BANK_PC:   r_pc        <= r_data;
                BANK_USR:  r_usr[idx]  <= r_data;
                BANK_FIQ:  r_fiq[idx]  <= r_data;
                BANK_EXC:  r_exc[idx]  <= r_data;
                BANK_SPSR: r_spsr[idx] <= r_data;
                BANK_CPSR: r_cpsr      <= r_data;
                default:   ;
            endcase
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action <= i_action;
            r_mode   <= i_mode;
            r_reg    <= i_reg_index;
            r_data   <= i_write_data;
        end
        if (advance) begin
            r_rd     <= n_rd;
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_rd;
    assign o_status    = r_status;

`include "assert_macros.svh"

    // an error result never carries data
    `CHK_SAME(a_err_zero, i_clk, i_rst_n, r_out_valid && (r_status != STAT_OK), r_rd == '0)

    // a cpsr write that completes is visible in the next cycle
    `CHK_NEXT(a_cpsr_wr, i_clk, i_rst_n, advance && (r_action == ACT_WR_CPSR), r_cpsr == $past(r_data))

    // stage one only moves on when the result slot is free
    `CHK_NEXT(a_hold_s1, i_clk, i_rst_n, r_s1_valid && r_out_valid && i_out_stall, r_s1_valid && r_out_valid)

    // status stays within its defined codes
    `CHK_SAME(a_status_rng, i_clk, i_rst_n, r_out_valid, r_status != 2'd3)

endmodule

>>> sim/abrf_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrf_access_checker
// watches both channels of the banked register file, keeps its own copy of
// every bank, predicts each result word and compares it in order
// ----------------------------------------------------------------------------
module abrf_access_checker
    import abrf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [ActionW-1:0] i_action,
    input  logic [ModeW-1:0]   i_mode,
    input  logic [RegW-1:0]    i_reg_index,
    input  logic [DataW-1:0]   i_write_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [DataW-1:0]   i_read_data,
    input  logic [StatusW-1:0] i_status,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    localparam int LowRegs  = 8;
    localparam int HighRegs = 7;
    localparam int ExcRegs  = 8;
    localparam int SpsrRegs = 5;

    typedef struct packed {
        logic [DataW-1:0] rdata;
        t_status          st;
    } t_access_result;

    logic [DataW-1:0] low_regs [LowRegs];
    logic [DataW-1:0] pc_reg;
    logic [DataW-1:0] usr_hi   [HighRegs];
    logic [DataW-1:0] fiq_hi   [HighRegs];
    logic [DataW-1:0] sp_lr    [ExcRegs];
    logic [DataW-1:0] spsr     [SpsrRegs];
    logic [DataW-1:0] cpsr;

    t_access_result expected_reads [$];
    int fails   = 0;
    int checked = 0;

    function automatic t_slot mode_slot(input logic [ModeW-1:0] mode);
        case (mode)
            MODE_FIQ: return SLOT_FIQ;
            MODE_IRQ: return SLOT_IRQ;
            MODE_SVC: return SLOT_SVC;
            MODE_ABT: return SLOT_ABT;
            MODE_UND: return SLOT_UND;
            default:  return SLOT_NONE;
        endcase
    endfunction

    // one access against the local copy of the banks
    task automatic bank_access(
        input  logic [ActionW-1:0] act,
        input  logic [ModeW-1:0]   mode,
        input  logic [RegW-1:0]    idx,
        input  logic [DataW-1:0]   wdata,
        output t_access_result     res
    );
        t_slot slot;
        t_bank bank;
        int    pos;
        logic  known;
        logic  is_write;
        slot     = mode_slot(mode);
        known    = (mode == MODE_USR) || (mode == MODE_SYS) || (slot != SLOT_NONE);
        bank     = BANK_NONE;
        pos      = 0;
        is_write = act[0];
        res.rdata = '0;
        res.st    = STAT_OK;
        case (act)
            ACT_RD_GPR, ACT_WR_GPR: begin
                if (!known) begin
                    res.st = STAT_BAD_MODE;
                end else if (int'(idx) < LowRegs) begin
                    bank = BANK_LOW;
                    pos  = int'(idx);
                end else if (idx == REG_PC) begin
                    bank = BANK_PC;
                end else if (slot == SLOT_FIQ) begin
                    bank = BANK_FIQ;
                    pos  = int'(idx) - LowRegs;
                end else if (idx < REG_SP || slot == SLOT_NONE) begin
                    bank = BANK_USR;
                    pos  = int'(idx) - LowRegs;
                end else begin
                    // sp/lr pairs of irq, svc, abt, und
                    bank = BANK_EXC;
                    pos  = 2 * (int'(slot) - int'(SLOT_IRQ)) + int'(idx) - int'(REG_SP);
                end
            end
            ACT_RD_SPSR, ACT_WR_SPSR: begin
                if (!known) begin
                    res.st = STAT_BAD_MODE;
                end else if (slot == SLOT_NONE) begin
                    res.st = STAT_NO_SPSR;
                end else begin
                    bank = BANK_SPSR;
                    pos  = int'(slot);
                end
            end
            ACT_RD_CPSR, ACT_WR_CPSR: begin
                bank = BANK_CPSR;
            end
            default: ;
        endcase
        case (bank)
            BANK_LOW:  if (is_write) low_regs[pos] = wdata; else res.rdata = low_regs[pos];
            BANK_PC:   if (is_write) pc_reg = wdata;        else res.rdata = pc_reg;
            BANK_USR:  if (is_write) usr_hi[pos] = wdata;   else res.rdata = usr_hi[pos];
            BANK_FIQ:  if (is_write) fiq_hi[pos] = wdata;   else res.rdata = fiq_hi[pos];
            BANK_EXC:  if (is_write) sp_lr[pos] = wdata;    else res.rdata = sp_lr[pos];
            BANK_SPSR: if (is_write) spsr[pos] = wdata;     else res.rdata = spsr[pos];
            BANK_CPSR: if (is_write) cpsr = wdata;          else res.rdata = cpsr;
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_access_result want;
        t_access_result fresh;
        if (!i_rst_n) begin
            foreach (low_regs[k]) low_regs[k] = '0;
            foreach (usr_hi[k])   usr_hi[k]   = '0;
            foreach (fiq_hi[k])   fiq_hi[k]   = '0;
            foreach (sp_lr[k])    sp_lr[k]    = '0;
            foreach (spsr[k])     spsr[k]     = '0;
            pc_reg = '0;
            cpsr   = '0;
            expected_reads.delete();
        end else begin
            // retire before predicting so a word with nothing waiting is caught
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (expected_reads.size() == 0) begin
                    $display("%0t: unexpected result word: expected none, got read_data %08h status %0d",
                             $time, i_read_data, i_status);
                    fails++;
                end else begin
                    want = expected_reads.pop_front();
                    if (i_read_data !== want.rdata) begin
                        $display("%0t: read_data mismatch: expected %08h, got %08h",
                                 $time, want.rdata, i_read_data);
                        fails++;
                    end
                    if (i_status !== want.st) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.st, i_status);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                bank_access(i_action, i_mode, i_reg_index, i_write_data, fresh);
                expected_reads.push_back(fresh);
            end
        end
        o_pending    <= expected_reads.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

>>> sim/tb_arm_banked_register_file.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arm_banked_register_file
// drives directed and random register accesses in every mode with random
// gaps and output stalls; a separate checker predicts and compares results
// ----------------------------------------------------------------------------
module tb_arm_banked_register_file;
    import abrf_pkg::*;

    // action codes the block treats as no-ops
    localparam logic [ActionW-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ActionW-1:0] ACT_SPARE_7 = 3'd7;

    // mode codes that are not processor modes
    localparam logic [ModeW-1:0] MODE_BAD_LO  = 5'd0;
    localparam logic [ModeW-1:0] MODE_BAD_MID = 5'd20;
    localparam logic [ModeW-1:0] MODE_BAD_HI  = 5'd30;

    localparam int RandomWords = 1800;
    localparam int MaxIdle     = 16;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [ActionW-1:0] action     = '0;
    logic [ModeW-1:0]   mode       = '0;
    logic [RegW-1:0]    reg_index  = '0;
    logic [DataW-1:0]   write_data = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [DataW-1:0]   read_data;
    logic [StatusW-1:0] status;

    logic        no_idle   = 1'b0;
    int unsigned hold_left = 0;
    int          fail_count;
    int          pending;
    int          checked;
    int          words_sent = 0;
    int          directed_words;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    arm_banked_register_file u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_action     (action),
        .i_mode       (mode),
        .i_reg_index  (reg_index),
        .i_write_data (write_data),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_read_data  (read_data),
        .o_status     (status)
    );

    abrf_access_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_action     (action),
        .i_mode       (mode),
        .i_reg_index  (reg_index),
        .i_write_data (write_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_read_data  (read_data),
        .i_status     (status),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // output side: after each word taken, stall for a random count of cycles
    always @(posedge clk) begin : result_sink
        int unsigned draw;
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end else if (out_valid && !out_stall) begin
            draw = no_idle ? 0 : $urandom_range(0, MaxIdle);
            hold_left <= draw;
            out_stall <= (draw != 0);
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
        end else begin
            hold_left <= 0;
            out_stall <= 1'b0;
        end
    end

    task automatic send_word(
        input logic [ActionW-1:0] act,
        input logic [ModeW-1:0]   md,
        input logic [RegW-1:0]    idx,
        input logic [DataW-1:0]   data
    );
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MaxIdle);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        mode       <= md;
        reg_index  <= idx;
        write_data <= data;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    function automatic logic [ModeW-1:0] pick_mode();
        if ($urandom_range(0, 99) >= 88) return ModeW'($urandom_range(0, 31));
        case ($urandom_range(0, 6))
            0: return MODE_USR;
            1: return MODE_FIQ;
            2: return MODE_IRQ;
            3: return MODE_SVC;
            4: return MODE_ABT;
            5: return MODE_UND;
            default: return MODE_SYS;
        endcase
    endfunction

    function automatic logic [ActionW-1:0] pick_action();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return ACT_RD_GPR;
        if (r < 60) return ACT_WR_GPR;
        if (r < 70) return ACT_RD_SPSR;
        if (r < 78) return ACT_WR_SPSR;
        if (r < 86) return ACT_RD_CPSR;
        if (r < 94) return ACT_WR_CPSR;
        if (r < 97) return ACT_SPARE_6;
        return ACT_SPARE_7;
    endfunction

    function automatic logic [DataW-1:0] pick_data();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return $urandom;
    endfunction

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // sharing and banking across modes
        send_word(ACT_RD_GPR,  MODE_USR,     4'd0,   32'h0000_0000);
        send_word(ACT_WR_GPR,  MODE_USR,     4'd0,   32'hFFFF_FFFF);
        send_word(ACT_RD_GPR,  MODE_FIQ,     4'd0,   32'h0000_0000);
        send_word(ACT_WR_GPR,  MODE_SVC,     REG_PC, 32'h8000_0000);
        send_word(ACT_RD_GPR,  MODE_SYS,     REG_PC, 32'h0000_0000);
        send_word(ACT_WR_GPR,  MODE_FIQ,     4'd8,   32'hA5A5_A5A5);
        send_word(ACT_RD_GPR,  MODE_USR,     4'd8,   32'h0000_0000);
        send_word(ACT_RD_GPR,  MODE_FIQ,     4'd8,   32'h0000_0000);
        send_word(ACT_WR_GPR,  MODE_IRQ,     REG_SP, 32'h1234_5678);
        send_word(ACT_RD_GPR,  MODE_SVC,     REG_SP, 32'h0000_0000);
        send_word(ACT_RD_GPR,  MODE_IRQ,     REG_SP, 32'h0000_0000);
        send_word(ACT_WR_GPR,  MODE_UND,     4'd14,  32'h0F0F_0F0F);
        send_word(ACT_WR_GPR,  MODE_ABT,     4'd12,  32'h5A5A_5A5A);
        send_word(ACT_RD_GPR,  MODE_SYS,     4'd12,  32'h0000_0000);
        // saved status, including user and system that have none
        send_word(ACT_WR_SPSR, MODE_FIQ,     4'd0,   32'h1111_1111);
        send_word(ACT_RD_SPSR, MODE_UND,     4'd0,   32'h0000_0000);
        send_word(ACT_WR_SPSR, MODE_USR,     4'd0,   32'hFFFF_FFFF);
        send_word(ACT_RD_SPSR, MODE_SYS,     4'd0,   32'h0000_0000);
        // invalid modes; cpsr ignores the mode
        send_word(ACT_WR_GPR,  MODE_BAD_LO,  4'd1,   32'hFFFF_FFFF);
        send_word(ACT_WR_SPSR, MODE_BAD_HI,  4'd0,   32'hFFFF_FFFF);
        send_word(ACT_WR_CPSR, MODE_BAD_LO,  4'd0,   32'hFFFF_FFFF);
        send_word(ACT_RD_CPSR, MODE_BAD_MID, 4'd0,   32'h0000_0000);
        send_word(ACT_RD_GPR,  MODE_BAD_HI,  4'd0,   32'h0000_0000);
        // unused action codes
        send_word(ACT_SPARE_6, MODE_USR,     4'd2,   32'hFFFF_FFFF);
        send_word(ACT_SPARE_7, MODE_FIQ,     4'd14,  32'hFFFF_FFFF);
        directed_words = words_sent;

        for (int i = 0; i < RandomWords; i++) begin
            // every fourth stretch runs back to back on both sides
            no_idle <= ((i / 150) % 4 == 3);
            send_word(pick_action(), pick_mode(), RegW'($urandom_range(0, 15)), pick_data());
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d words (%0d directed, the rest random over all modes, actions",
                 words_sent, directed_words);
        $display("and registers with random gaps and stalls); %0d result words checked", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("** arm_banked_register_file: PASSED **");
        end else begin
            $display("** arm_banked_register_file: FAILED **");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d result words outstanding", pending);
        $display("** arm_banked_register_file: FAILED **");
        $finish;
    end

endmodule
